@@ design/adrp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the audio downmix / resample / PWM block.
// No dependencies; every other file of the block imports this package.
package adrp_pkg;

   // Input sample width codes
   typedef enum logic [1:0] {
      FMT_8  = 2'd0,
      FMT_16 = 2'd1,
      FMT_24 = 2'd2,
      FMT_32 = 2'd3
   } fmt_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_SAMPLE_FORMAT = 2'd0,
      CSR_CHANNEL_COUNT = 2'd1,
      CSR_PHASE_STEP    = 2'd2,
      CSR_PWM_PERIOD    = 2'd3
   } csr_index_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_MUL  = 2'd1,
      ST_MIX  = 2'd2,
      ST_DUTY = 2'd3
   } back_state_type;

   localparam int SAMPLE_W     = 16;
   localparam int RAW_W        = 32;
   localparam int CHAN_W       = 2;
   localparam int STEP_W       = 37;
   localparam int PERIOD_W     = 16;
   localparam int FRAC_W       = 32;
   localparam int SKIP_W       = 6;
   localparam int MAX_OUTS     = 8;
   localparam int OUT_CNT_W    = $clog2(MAX_OUTS);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAN_W-1:0]   CHAN_STEREO    = 2'd2;
   localparam logic [CHAN_W-1:0]   CHAN_RESET     = 2'd1;
   localparam logic [STEP_W-1:0]   STEP_RESET     = 37'h1_0000_0000;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 16'd16000;
   localparam logic [SKIP_W-1:0]   SKIP_RESET     = 6'd2;

endpackage

@@ design/adrp_front.sv @@
`timescale 1ns / 1ps
// Front end: takes request frames and reduces them to one 16-bit mono sample.
// Depends on adrp_pkg; pushes into adrp_queue.
module adrp_front (
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [adrp_pkg::RAW_W-1:0]      req_sample_left,
   input  logic [adrp_pkg::RAW_W-1:0]      req_sample_right,
   input  adrp_pkg::fmt_type               sample_format,
   input  logic [adrp_pkg::CHAN_W-1:0]     channel_count,
   input  logic                            queue_full,
   output logic                            push,
   output logic [adrp_pkg::SAMPLE_W-1:0]   push_sample
);
   import adrp_pkg::*;

   logic [RAW_W:0]    left_wide;
   logic [RAW_W:0]    right_wide;
   logic [RAW_W:0]    pair_sum;
   logic              stereo;
   logic [SAMPLE_W-1:0] mono_sample;
   logic [SAMPLE_W-1:0] stereo_sample;

   // Take a request whenever the queue has room
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign stereo    = (channel_count == CHAN_STEREO);

   // Sign-extend both channels at the configured width
   always_comb begin
      unique case (sample_format)
         FMT_8: begin
            left_wide  = {{(RAW_W-7){req_sample_left[7]}},   req_sample_left[7:0]};
            right_wide = {{(RAW_W-7){req_sample_right[7]}},  req_sample_right[7:0]};
         end
         FMT_16: begin
            left_wide  = {{(RAW_W-15){req_sample_left[15]}},  req_sample_left[15:0]};
            right_wide = {{(RAW_W-15){req_sample_right[15]}}, req_sample_right[15:0]};
         end
         FMT_24: begin
            left_wide  = {{(RAW_W-23){req_sample_left[23]}},  req_sample_left[23:0]};
            right_wide = {{(RAW_W-23){req_sample_right[23]}}, req_sample_right[23:0]};
         end
         default: begin
            left_wide  = {req_sample_left[31],  req_sample_left};
            right_wide = {req_sample_right[31], req_sample_right};
         end
      endcase
   end

   assign pair_sum = left_wide + right_wide;

   // Scale to 16 bits; the floor shifts are plain bit selects
   always_comb begin
      unique case (sample_format)
         FMT_8: begin
            mono_sample   = {req_sample_left[7], req_sample_left[7:0], 7'b0};
            stereo_sample = {pair_sum[8:0], 7'b0};
         end
         FMT_16: begin
            mono_sample   = req_sample_left[15:0];
            stereo_sample = pair_sum[16:1];
         end
         FMT_24: begin
            mono_sample   = req_sample_left[23:8];
            stereo_sample = pair_sum[24:9];
         end
         default: begin
            mono_sample   = req_sample_left[31:16];
            stereo_sample = pair_sum[32:17];
         end
      endcase
   end

   assign push_sample = stereo ? stereo_sample : mono_sample;

endmodule

@@ design/adrp_queue.sv @@
`timescale 1ns / 1ps
// Short queue of mono samples between the front and back ends.
// Depends on adrp_pkg for depth and width.
module adrp_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic [adrp_pkg::SAMPLE_W-1:0]   push_sample,
   output logic                            full,
   input  logic                            pop,
   output logic                            head_valid,
   output logic [adrp_pkg::SAMPLE_W-1:0]   head_sample
);
   import adrp_pkg::*;

   logic [SAMPLE_W-1:0]    entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full        = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid  = (count_ff != '0);
   assign head_sample = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed sample
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_sample;
      end
   end

endmodule

@@ design/adrp_back.sv @@
`timescale 1ns / 1ps
// Back end: sample window, phase accumulator, interpolation and PWM duty.
// Depends on adrp_pkg; pops from adrp_queue and drives the response register.
module adrp_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [adrp_pkg::STEP_W-1:0]     phase_step,
   input  logic [adrp_pkg::PERIOD_W-1:0]   pwm_period,
   input  logic                            head_valid,
   input  logic [adrp_pkg::SAMPLE_W-1:0]   head_sample,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [adrp_pkg::PERIOD_W-1:0]   rsp_pwm_duty,
   output logic signed [adrp_pkg::SAMPLE_W-1:0] rsp_resampled_sample,
   output logic                            rsp_last_of_run
);
   import adrp_pkg::*;

   back_state_type            state_ff, state_in;
   logic signed [SAMPLE_W-1:0] older_ff, older_in;
   logic signed [SAMPLE_W-1:0] newer_ff, newer_in;
   logic [FRAC_W-1:0]         frac_ff, frac_in;
   logic [SKIP_W-1:0]         skip_ff, skip_in;
   logic [OUT_CNT_W-1:0]      cnt_ff, cnt_in;
   logic signed [2*SAMPLE_W+1:0] prod_ff, prod_in;
   logic signed [SAMPLE_W-1:0] mix_ff, mix_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PERIOD_W-1:0]       rsp_duty_ff, rsp_duty_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic signed [SAMPLE_W:0]   diff;
   logic signed [SAMPLE_W:0]   weight;
   logic signed [SAMPLE_W+1:0] mix_sum;
   logic [SAMPLE_W-1:0]        offset;
   logic [2*PERIOD_W-1:0]      duty_prod;
   logic [STEP_W:0]            acc;
   logic [SKIP_W-1:0]          whole;
   logic [SKIP_W-1:0]          skip_dec;
   logic                       out_load;
   logic                       last_hit;

   // Datapath terms shared by the sequencer
   assign diff      = {newer_ff[SAMPLE_W-1], newer_ff} - {older_ff[SAMPLE_W-1], older_ff};
   assign weight    = $signed({1'b0, frac_ff[FRAC_W-1 -: SAMPLE_W]});
   assign mix_sum   = {{2{older_ff[SAMPLE_W-1]}}, older_ff} + prod_ff[2*SAMPLE_W+1:SAMPLE_W];
   assign offset    = {~mix_ff[SAMPLE_W-1], mix_ff[SAMPLE_W-2:0]};
   assign duty_prod = offset * pwm_period;
   assign acc       = {{(STEP_W+1-FRAC_W){1'b0}}, frac_ff} + {1'b0, phase_step};
   assign whole     = acc[STEP_W:FRAC_W];
   assign skip_dec  = (skip_ff != '0) ? skip_ff - 1'b1 : skip_ff;

   // Sequence: pop and shift window, multiply, mix, then scale and send
   always_comb begin
      state_in      = state_ff;
      older_in      = older_ff;
      newer_in      = newer_ff;
      frac_in       = frac_ff;
      skip_in       = skip_ff;
      cnt_in        = cnt_ff;
      prod_in       = prod_ff;
      mix_in        = mix_ff;
      rsp_duty_in   = rsp_duty_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      pop           = 1'b0;
      out_load      = 1'b0;
      last_hit      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               older_in = newer_ff;
               newer_in = head_sample;
               skip_in  = skip_dec;
               cnt_in   = '0;
               if (skip_dec == '0) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = diff * weight;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            mix_in   = mix_sum[SAMPLE_W-1:0];
            state_in = ST_DUTY;
         end
         ST_DUTY: begin
            // Wait here while the response register is held
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               frac_in  = acc[FRAC_W-1:0];
               cnt_in   = cnt_ff + 1'b1;
               if (whole != '0) begin
                  skip_in  = whole;
                  last_hit = 1'b1;
               end else if (cnt_ff == OUT_CNT_W'(MAX_OUTS - 1)) begin
                  skip_in  = SKIP_W'(1);
                  last_hit = 1'b1;
               end
               rsp_duty_in   = duty_prod[2*PERIOD_W-1:PERIOD_W];
               rsp_sample_in = mix_ff;
               rsp_last_in   = last_hit;
               state_in      = last_hit ? ST_IDLE : ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         older_ff     <= '0;
         newer_ff     <= '0;
         frac_ff      <= '0;
         skip_ff      <= SKIP_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         older_ff     <= older_in;
         newer_ff     <= newer_in;
         frac_ff      <= frac_in;
         skip_ff      <= skip_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and response payload
   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      mix_ff        <= mix_in;
      rsp_duty_ff   <= rsp_duty_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pwm_duty         = rsp_duty_ff;
   assign rsp_resampled_sample = rsp_sample_ff;
   assign rsp_last_of_run      = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // An eighth output always closes the run
   a_max_outs: assert property (@(posedge clock) disable iff (reset)
      (out_load && cnt_ff == OUT_CNT_W'(MAX_OUTS - 1)) |-> last_hit)
      else $error("eighth output not marked last");

   // A closing output returns the sequencer to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_hit) |=> (state_ff == ST_IDLE && rsp_last_of_run))
      else $error("run did not close after last output");

   // Interpolation only runs with the skip count exhausted
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (skip_ff == '0))
      else $error("interpolating while frames remain to skip");

   // No new frame is taken while outputs of a run are pending
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE))
      else $error("frame popped mid-run");
`endif

endmodule

@@ design/audio_downmix_resample_pwm_top.sv @@
`timescale 1ns / 1ps
// Top level of the audio downmix / resample / PWM block: CSRs and wiring.
// Depends on adrp_pkg, adrp_front, adrp_queue and adrp_back.
//
// Usage:
//   Request channel (req_valid / req_stall) takes one stereo or mono frame,
//   raw samples sign-extended at the configured width. The front end turns
//   each frame into a 16-bit mono sample and parks it in a two-entry queue.
//   Response channel (rsp_valid / rsp_stall) returns zero to eight 8 kHz
//   outputs per frame: PWM duty, interpolated sample, and a flag on the last
//   output caused by that frame.
//   CSR channel (csr_valid / csr_ready) writes a register by index; it is
//   always ready. Write only while no frame is in flight.
//   The back end shifts the window once per frame, then runs multiply, mix
//   and duty multiply for each output, and pops the next frame only when
//   back in idle. A taken request is registered in the queue, then popped,
//   multiplied, mixed and scaled into the registered response.
//   Reset loads the register defaults, empties the queue and clears the
//   window; the first frame after reset only fills it and produces no output.
//   While rsp_stall is high the response is held and the back end waits;
//   the queue keeps taking requests until it is full, then req_stall rises.
module audio_downmix_resample_pwm_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [adrp_pkg::RAW_W-1:0] req_sample_left,
   input  logic signed [adrp_pkg::RAW_W-1:0] req_sample_right,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [adrp_pkg::PERIOD_W-1:0]   rsp_pwm_duty,
   output logic signed [adrp_pkg::SAMPLE_W-1:0] rsp_resampled_sample,
   output logic                            rsp_last_of_run,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [adrp_pkg::STEP_W-1:0]     csr_data
);
   import adrp_pkg::*;

   fmt_type               sample_format_ff;
   logic [CHAN_W-1:0]     channel_count_ff;
   logic [STEP_W-1:0]     phase_step_ff;
   logic [PERIOD_W-1:0]   pwm_period_ff;

   logic                  queue_full;
   logic                  push;
   logic [SAMPLE_W-1:0]   push_sample;
   logic                  pop;
   logic                  head_valid;
   logic [SAMPLE_W-1:0]   head_sample;

   assign csr_ready = 1'b1;

   // Update configuration registers on a write
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_format_ff <= FMT_16;
         channel_count_ff <= CHAN_RESET;
         phase_step_ff    <= STEP_RESET;
         pwm_period_ff    <= PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SAMPLE_FORMAT: sample_format_ff <= fmt_type'(csr_data[1:0]);
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_data[CHAN_W-1:0];
            CSR_PHASE_STEP:    phase_step_ff    <= csr_data;
            CSR_PWM_PERIOD:    pwm_period_ff    <= csr_data[PERIOD_W-1:0];
            default:           ;
         endcase
      end
   end

   adrp_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .sample_format    (sample_format_ff),
      .channel_count    (channel_count_ff),
      .queue_full       (queue_full),
      .push             (push),
      .push_sample      (push_sample)
   );

   adrp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_sample (push_sample),
      .full        (queue_full),
      .pop         (pop),
      .head_valid  (head_valid),
      .head_sample (head_sample)
   );

   adrp_back u_back (
      .clock                (clock),
      .reset                (reset),
      .phase_step           (phase_step_ff),
      .pwm_period           (pwm_period_ff),
      .head_valid           (head_valid),
      .head_sample          (head_sample),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pwm_duty         (rsp_pwm_duty),
      .rsp_resampled_sample (rsp_resampled_sample),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

@@ dv/audio_downmix_resample_pwm_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for audio_downmix_resample_pwm_top: random and directed
// frames, with a built-in predictor of the downmix, resampler and PWM duty.
// Depends on adrp_pkg and the block's RTL only.
module audio_downmix_resample_pwm_top_test;
   import adrp_pkg::*;

   localparam logic [CHAN_W-1:0] CHAN_MONO      = 2'd1;
   // Channel counts other than two also mean mono
   localparam logic [CHAN_W-1:0] CHAN_MONO_ALT0 = 2'd0;
   localparam logic [CHAN_W-1:0] CHAN_MONO_ALT3 = 2'd3;
   localparam logic [STEP_W-1:0] STEP_TINY      = 37'd536870911;
   localparam logic [STEP_W-1:0] STEP_LOW       = 37'd536870912;
   localparam logic [STEP_W-1:0] STEP_HIGH      = 37'd103079215104;
   localparam logic [STEP_W-1:0] STEP_MAX       = 37'h1F_FFFF_FFFF;
   localparam int QUIET_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_PHASES = 12;
   localparam int FRAMES_PER_PHASE = 30;

   typedef struct packed {
      logic [RAW_W-1:0] left;
      logic [RAW_W-1:0] right;
   } stereo_frame_type;

   typedef struct packed {
      logic [PERIOD_W-1:0]        duty;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } pwm_output_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [RAW_W-1:0] req_sample_left = '0;
   logic signed [RAW_W-1:0] req_sample_right = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [PERIOD_W-1:0] rsp_pwm_duty;
   logic signed [SAMPLE_W-1:0] rsp_resampled_sample;
   logic rsp_last_of_run;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [STEP_W-1:0] csr_data = '0;

   // Register shadow, updated as each write lands
   fmt_type             fmt_cfg    = FMT_16;
   logic [CHAN_W-1:0]   chan_cfg   = CHAN_RESET;
   logic [STEP_W-1:0]   step_cfg   = STEP_RESET;
   logic [PERIOD_W-1:0] period_cfg = PERIOD_RESET;

   // Resampler state as the predictor sees it
   logic signed [SAMPLE_W-1:0] older_mono  = '0;
   logic signed [SAMPLE_W-1:0] newer_mono  = '0;
   logic [FRAC_W-1:0]          phase_frac  = '0;
   logic [SKIP_W-1:0]          frames_left = SKIP_RESET;

   stereo_frame_type pending_frames[$];
   pwm_output_type   expected_outputs[$];
   stereo_frame_type frame_on_bus;
   pwm_output_type   oldest_output;
   int frames_queued = 0;
   int frames_accepted = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 20;
   int recv_stall_pct = 73;

   audio_downmix_resample_pwm_top i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_sample_left      (req_sample_left),
      .req_sample_right     (req_sample_right),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pwm_duty         (rsp_pwm_duty),
      .rsp_resampled_sample (rsp_resampled_sample),
      .rsp_last_of_run      (rsp_last_of_run),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Reduce one frame to a 16-bit mono sample; stereo sums are taken wide
   function automatic logic signed [SAMPLE_W-1:0] mono_of_frame(stereo_frame_type fr);
      longint l, r, m;
      logic stereo;
      stereo = (chan_cfg == CHAN_STEREO);
      case (fmt_cfg)
         FMT_8: begin
            l = longint'($signed(fr.left[7:0]));
            r = longint'($signed(fr.right[7:0]));
            m = stereo ? (l + r) * 128 : l * 128;
         end
         FMT_16: begin
            l = longint'($signed(fr.left[15:0]));
            r = longint'($signed(fr.right[15:0]));
            m = stereo ? (l + r) >>> 1 : l;
         end
         FMT_24: begin
            l = longint'($signed(fr.left[23:0]));
            r = longint'($signed(fr.right[23:0]));
            m = stereo ? (l + r) >>> 9 : l >>> 8;
         end
         default: begin
            l = longint'($signed(fr.left));
            r = longint'($signed(fr.right));
            m = stereo ? (l + r) >>> 17 : l >>> 16;
         end
      endcase
      return m[SAMPLE_W-1:0];
   endfunction

   // Shift the window, count down the skip, then emit the interpolated outputs
   function automatic void resample_frame(stereo_frame_type fr);
      longint weight, diff, level, duty;
      logic [STEP_W:0] acc;
      int n;
      logic done;
      pwm_output_type res;
      older_mono = newer_mono;
      newer_mono = mono_of_frame(fr);
      if (frames_left != 0) frames_left = frames_left - 1'b1;
      if (frames_left != 0) return;
      n = 0;
      done = 1'b0;
      while (!done) begin
         weight = longint'(phase_frac[31:16]);
         diff = longint'(newer_mono) - longint'(older_mono);
         level = longint'(older_mono) + ((diff * weight) >>> 16);
         duty = ((level + 32768) * longint'(period_cfg)) >>> 16;
         acc = (STEP_W+1)'(phase_frac) + (STEP_W+1)'(step_cfg);
         phase_frac = acc[FRAC_W-1:0];
         n++;
         if (acc[STEP_W:FRAC_W] != 0) begin
            frames_left = SKIP_W'(acc[STEP_W:FRAC_W]);
            done = 1'b1;
         end else if (n >= MAX_OUTS) begin
            // step too small: advance the window anyway
            frames_left = SKIP_W'(1);
            done = 1'b1;
         end
         res.duty = duty[PERIOD_W-1:0];
         res.sample = level[SAMPLE_W-1:0];
         res.last = done;
         expected_outputs.push_back(res);
      end
   endfunction

   // Request driver: hold a stalled request, otherwise send the next or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            resample_frame(frame_on_bus);
            frames_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               frame_on_bus = pending_frames.pop_front();
               req_sample_left <= frame_on_bus.left;
               req_sample_right <= frame_on_bus.right;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each output against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected output at cycle %0d: duty %0d sample %0d last %0b",
                        cycle_count, rsp_pwm_duty, rsp_resampled_sample, rsp_last_of_run);
            mismatch_count++;
         end else begin
            oldest_output = expected_outputs.pop_front();
            if (rsp_pwm_duty !== oldest_output.duty ||
                rsp_resampled_sample !== oldest_output.sample ||
                rsp_last_of_run !== oldest_output.last) begin
               if (mismatch_count < 10)
                  $display("mismatch cycle %0d: exp %0d %0d %0b, got %0d %0d %0b",
                           cycle_count, oldest_output.duty, oldest_output.sample,
                           oldest_output.last, rsp_pwm_duty, rsp_resampled_sample,
                           rsp_last_of_run);
               mismatch_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic queue_frame(logic [RAW_W-1:0] left, logic [RAW_W-1:0] right);
      stereo_frame_type fr;
      fr.left = left;
      fr.right = right;
      pending_frames.push_back(fr);
      frames_queued++;
   endtask

   // Wait for every request to be taken and every output to drain
   task automatic settle();
      while (!(frames_accepted == frames_queued && expected_outputs.size() == 0))
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [STEP_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SAMPLE_FORMAT: fmt_cfg = fmt_type'(data[1:0]);
         CSR_CHANNEL_COUNT: chan_cfg = data[CHAN_W-1:0];
         CSR_PHASE_STEP:    step_cfg = data;
         CSR_PWM_PERIOD:    period_cfg = data[PERIOD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_config(fmt_type f, logic [CHAN_W-1:0] ch,
                               logic [STEP_W-1:0] st, logic [PERIOD_W-1:0] per);
      csr_write(CSR_SAMPLE_FORMAT, STEP_W'(f));
      csr_write(CSR_CHANNEL_COUNT, STEP_W'(ch));
      csr_write(CSR_PHASE_STEP, st);
      csr_write(CSR_PWM_PERIOD, STEP_W'(per));
      csr_valid <= 1'b0;
   endtask

   // Mostly full random words, sometimes a sign boundary of one of the widths
   function automatic logic [RAW_W-1:0] random_raw();
      if ($urandom_range(7) != 0) return $urandom;
      case ($urandom_range(7))
         0: return 32'h0000_007F;
         1: return 32'h0000_0080;
         2: return 32'h0000_7FFF;
         3: return 32'h0000_8000;
         4: return 32'h007F_FFFF;
         5: return 32'h0080_0000;
         6: return 32'h7FFF_FFFF;
         default: return 32'h8000_0000;
      endcase
   endfunction

   // Common audio rates, uniform over the range, or steps from STEP_LOW to below STEP_LOW plus 2.0
   function automatic logic [STEP_W-1:0] random_step();
      logic [63:0] pick;
      longint unsigned rate;
      case ($urandom_range(3))
         0: begin
            case ($urandom_range(6))
               0: rate = 8000;
               1: rate = 11025;
               2: rate = 16000;
               3: rate = 22050;
               4: rate = 44100;
               5: rate = 48000;
               default: rate = 192000;
            endcase
            pick = ((rate << 32) + 4000) / 8000;
         end
         1: pick = 64'(STEP_LOW) +
                   ({$urandom, $urandom} % (64'(STEP_HIGH) - 64'(STEP_LOW) + 1));
         default: pick = 64'(STEP_LOW) + 64'($urandom) + (64'($urandom_range(1)) << 32);
      endcase
      return pick[STEP_W-1:0];
   endfunction

   initial begin : stimulus
      fmt_type f;
      logic [CHAN_W-1:0] ch;
      logic [STEP_W-1:0] st;
      logic [PERIOD_W-1:0] per;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: first frame only fills the window, 16-bit extremes
      queue_frame(32'h0000_7FFF, 32'h0);
      queue_frame(32'hFFFF_8000, 32'h0);
      queue_frame(32'h7FFF_FFFF, 32'hFFFF_FFFF);
      queue_frame(32'h8000_0000, 32'h7FFF_FFFF);
      queue_frame(32'h1234_5678, 32'h0);
      settle();

      // 32-bit stereo with wide sums, step too small, period zero
      write_config(FMT_32, CHAN_STEREO, STEP_TINY, 16'd0);
      queue_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_frame(32'h8000_0000, 32'h8000_0000);
      queue_frame(32'h7FFF_FFFF, 32'h8000_0000);
      queue_frame(32'h0000_0000, 32'hFFFF_FFFF);
      settle();

      // 8-bit stereo, smallest legal step, full period
      write_config(FMT_8, CHAN_STEREO, STEP_LOW, 16'hFFFF);
      queue_frame(32'h0000_007F, 32'h0000_007F);
      queue_frame(32'h0000_0080, 32'h0000_0080);
      queue_frame(32'hFFFF_FF7F, 32'h0000_0080);
      queue_frame(32'h0000_0080, 32'h0000_007F);
      queue_frame(32'hAB12_3401, 32'h5500_00FF);
      settle();

      // 24-bit mono through channel count zero, zero step, unit period
      write_config(FMT_24, CHAN_MONO_ALT0, '0, 16'd1);
      queue_frame(32'h007F_FFFF, 32'h0);
      queue_frame(32'h0080_0000, 32'h0);
      queue_frame(32'hFF7F_FFFF, 32'hFFFF_FFFF);
      settle();

      // Channel count three is mono too; widest step skips many frames
      write_config(FMT_24, CHAN_MONO_ALT3, STEP_MAX, 16'd1);
      queue_frame(32'h00FF_FFFF, 32'h0080_0000);
      queue_frame(32'h0000_0001, 32'h007F_FFFF);
      settle();

      // Random phases: sender-light, then receiver-light, then no idling
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         f = fmt_type'($urandom_range(3));
         case ($urandom_range(9))
            0: ch = CHAN_MONO_ALT0;
            1: ch = CHAN_MONO_ALT3;
            2, 3, 4, 5: ch = CHAN_STEREO;
            default: ch = CHAN_MONO;
         endcase
         st = random_step();
         per = 16'($urandom_range(65535, 1));
         if (p == 0) begin
            st = STEP_LOW;
            per = 16'hFFFF;
         end else if (p == 1) begin
            st = STEP_HIGH;
            per = 16'd1;
         end
         if (p < RANDOM_PHASES / 3) begin
            send_idle_pct = 20;
            recv_stall_pct = 73;
         end else if (p < 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 73;
            recv_stall_pct = 20;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         write_config(f, ch, st, per);
         for (int i = 0; i < FRAMES_PER_PHASE; i++)
            queue_frame(random_raw(), random_raw());
         settle();
      end

      if (mismatch_count == 0 && expected_outputs.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/adrp_pkg.sv
design/adrp_front.sv
design/adrp_queue.sv
design/adrp_back.sv
design/audio_downmix_resample_pwm_top.sv
dv/audio_downmix_resample_pwm_top_test.sv
